// ===== rtl/teq_pkg.sv =====
// Package for the touch event qualifier: types, register map and reset values.
package teq_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int FIELD_W        = 16;
  localparam int ADDR_BITS      = 5;
  localparam int DATA_BITS      = 32;
  localparam int REG_IDX_BITS   = 3;
  localparam int READY_BIT      = 7;

  localparam logic [3:0] STEADY_MAX = 4'd15;

  localparam logic [REG_IDX_BITS-1:0] REG_X_LIMIT          = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_Y_LIMIT          = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_MOVE_STEP        = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_JITTER_LIMIT     = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_PRESS_THRESHOLD  = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_RELEASE_AT_PRESS = 3'd5;

  localparam logic [15:0] X_LIMIT_RST          = 16'd480;
  localparam logic [15:0] Y_LIMIT_RST          = 16'd272;
  localparam logic [7:0]  MOVE_STEP_RST        = 8'd3;
  localparam logic [9:0]  JITTER_LIMIT_RST     = 10'd30;
  localparam logic [3:0]  PRESS_THRESHOLD_RST  = 4'd3;
  localparam logic        RELEASE_AT_PRESS_RST = 1'b0;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_DOWN = 2'd1,
    EV_MOVE = 2'd2,
    EV_UP   = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [15:0] x_limit;
    logic [15:0] y_limit;
    logic [7:0]  move_step;
    logic [9:0]  jitter_limit;
    logic [3:0]  press_threshold;
    logic        release_at_press;
  } cfg_t;

endpackage

// ===== rtl/teq_cfg.sv =====
// APB register file for the touch event qualifier settings.
module teq_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [teq_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [teq_pkg::DATA_BITS-1:0]   pwdata,
  output logic [teq_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready,
  output teq_pkg::cfg_t                   cfg
);

  logic                               wr_en;
  logic [teq_pkg::REG_IDX_BITS-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[teq_pkg::ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.x_limit          <= teq_pkg::X_LIMIT_RST;
      cfg.y_limit          <= teq_pkg::Y_LIMIT_RST;
      cfg.move_step        <= teq_pkg::MOVE_STEP_RST;
      cfg.jitter_limit     <= teq_pkg::JITTER_LIMIT_RST;
      cfg.press_threshold  <= teq_pkg::PRESS_THRESHOLD_RST;
      cfg.release_at_press <= teq_pkg::RELEASE_AT_PRESS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        teq_pkg::REG_X_LIMIT:          cfg.x_limit          <= pwdata[15:0];
        teq_pkg::REG_Y_LIMIT:          cfg.y_limit          <= pwdata[15:0];
        teq_pkg::REG_MOVE_STEP:        cfg.move_step        <= pwdata[7:0];
        teq_pkg::REG_JITTER_LIMIT:     cfg.jitter_limit     <= pwdata[9:0];
        teq_pkg::REG_PRESS_THRESHOLD:  cfg.press_threshold  <= pwdata[3:0];
        teq_pkg::REG_RELEASE_AT_PRESS: cfg.release_at_press <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      teq_pkg::REG_X_LIMIT:          prdata = teq_pkg::DATA_BITS'(cfg.x_limit);
      teq_pkg::REG_Y_LIMIT:          prdata = teq_pkg::DATA_BITS'(cfg.y_limit);
      teq_pkg::REG_MOVE_STEP:        prdata = teq_pkg::DATA_BITS'(cfg.move_step);
      teq_pkg::REG_JITTER_LIMIT:     prdata = teq_pkg::DATA_BITS'(cfg.jitter_limit);
      teq_pkg::REG_PRESS_THRESHOLD:  prdata = teq_pkg::DATA_BITS'(cfg.press_threshold);
      teq_pkg::REG_RELEASE_AT_PRESS: prdata = teq_pkg::DATA_BITS'(cfg.release_at_press);
      default:                       prdata = '0;
    endcase
  end

endmodule

// ===== rtl/teq_core.sv =====
// Per-sample qualifier: press/move/release decision and tracking state.
module teq_core #(
  parameter int COORD_BITS = teq_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  teq_pkg::cfg_t                 cfg,
  input  logic                          advance,
  input  logic                          read_ok,
  input  logic [7:0]                    status_byte,
  input  logic [COORD_BITS-1:0]         x,
  input  logic [COORD_BITS-1:0]         y,
  output teq_pkg::event_kind_t          ev_kind,
  output logic [teq_pkg::FIELD_W-1:0]   ev_x,
  output logic [teq_pkg::FIELD_W-1:0]   ev_y
);

  localparam int DW = (COORD_BITS > 10) ? COORD_BITS : 10;

  logic                  pressed, pressed_next;
  logic [3:0]            steady_count, steady_count_next;
  logic [COORD_BITS-1:0] last_x, last_x_next, last_y, last_y_next;
  logic [COORD_BITS-1:0] press_x, press_x_next, press_y, press_y_next;
  logic [COORD_BITS-1:0] dx, dy;
  logic                  out_of_range, steady, moved;

  assign dx = (x >= last_x) ? x - last_x : last_x - x;
  assign dy = (y >= last_y) ? y - last_y : last_y - y;
  assign out_of_range = (teq_pkg::FIELD_W'(x) > cfg.x_limit) ||
                        (teq_pkg::FIELD_W'(y) > cfg.y_limit);
  assign steady = (DW'(dx) <= DW'(cfg.jitter_limit)) && (DW'(dy) <= DW'(cfg.jitter_limit));
  assign moved  = (dx >= COORD_BITS'(cfg.move_step)) || (dy >= COORD_BITS'(cfg.move_step));

  always_comb begin
    pressed_next      = pressed;
    steady_count_next = steady_count;
    last_x_next       = last_x;
    last_y_next       = last_y;
    press_x_next      = press_x;
    press_y_next      = press_y;
    ev_kind           = teq_pkg::EV_NONE;
    ev_x              = '0;
    ev_y              = '0;
    if (!read_ok) begin
      pressed_next = 1'b0;
    end else if (out_of_range) begin
      pressed_next      = 1'b0;
      steady_count_next = '0;
    end else if (!status_byte[teq_pkg::READY_BIT]) begin
      pressed_next      = 1'b0;
      steady_count_next = '0;
      ev_kind           = teq_pkg::EV_UP;
      if (cfg.release_at_press) begin
        ev_x = teq_pkg::FIELD_W'(press_x);
        ev_y = teq_pkg::FIELD_W'(press_y);
      end else begin
        ev_x = teq_pkg::FIELD_W'(x);
        ev_y = teq_pkg::FIELD_W'(y);
      end
    end else if (!pressed) begin
      if (steady_count > cfg.press_threshold) begin
        pressed_next = 1'b1;
        ev_kind      = teq_pkg::EV_DOWN;
        ev_x         = teq_pkg::FIELD_W'(x);
        ev_y         = teq_pkg::FIELD_W'(y);
      end else if ((steady || steady_count == '0) && steady_count != teq_pkg::STEADY_MAX) begin
        steady_count_next = steady_count + 4'd1;
      end
      last_x_next  = x;
      last_y_next  = y;
      press_x_next = x;
      press_y_next = y;
    end else if (moved) begin
      last_x_next = x;
      last_y_next = y;
      ev_kind     = teq_pkg::EV_MOVE;
      ev_x        = teq_pkg::FIELD_W'(x);
      ev_y        = teq_pkg::FIELD_W'(y);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed      <= 1'b0;
      steady_count <= '0;
      last_x       <= '0;
      last_y       <= '0;
      press_x      <= '0;
      press_y      <= '0;
    end else if (advance) begin
      pressed      <= pressed_next;
      steady_count <= steady_count_next;
      last_x       <= last_x_next;
      last_y       <= last_y_next;
      press_x      <= press_x_next;
      press_y      <= press_y_next;
    end
  end

endmodule

// ===== rtl/touch_event_qualifier.sv =====
// Top level of the touch event qualifier: sample register, qualifier, event register.
//
//  channel   direction  handshake           payload
//  sample    in         in_valid/in_stall   read_ok, status_byte, sample_x, sample_y
//  event     out        out_valid/out_stall event_kind, event_x, event_y
//  config    in         APB psel/penable    paddr, pwdata, prdata
//
// One sample per cycle unless stalled; each goes through sample, then event register.
// The decision is one pass of compares and subtractions between the two registers.
// Synchronous reset clears control, tracking state and settings; no clearing pass.
// A stalled event holds its register; the sample register then holds and in_stall rises.
module touch_event_qualifier #(
  parameter int COORD_BITS = teq_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            read_ok,
  input  logic [7:0]                      status_byte,
  input  logic [teq_pkg::FIELD_W-1:0]     sample_x,
  input  logic [teq_pkg::FIELD_W-1:0]     sample_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      event_kind,
  output logic [teq_pkg::FIELD_W-1:0]     event_x,
  output logic [teq_pkg::FIELD_W-1:0]     event_y,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [teq_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [teq_pkg::DATA_BITS-1:0]   pwdata,
  output logic [teq_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready
);

  teq_pkg::cfg_t          cfg;
  logic                   s1_valid;
  logic                   s1_read_ok;
  logic [7:0]             s1_status;
  logic [COORD_BITS-1:0]  s1_x, s1_y;
  logic                   in_accept, advance;
  teq_pkg::event_kind_t   ev_kind;
  logic [teq_pkg::FIELD_W-1:0] ev_x, ev_y;

  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && !advance;
  assign in_accept = in_valid && !in_stall;

  teq_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_read_ok <= read_ok;
      s1_status  <= status_byte;
      s1_x       <= sample_x[COORD_BITS-1:0];
      s1_y       <= sample_y[COORD_BITS-1:0];
    end
  end

  teq_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .advance     (advance),
    .read_ok     (s1_read_ok),
    .status_byte (s1_status),
    .x           (s1_x),
    .y           (s1_y),
    .ev_kind     (ev_kind),
    .ev_x        (ev_x),
    .ev_y        (ev_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_kind <= ev_kind;
      event_x    <= ev_x;
      event_y    <= ev_y;
    end
  end

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !in_stall)
    else $error("in_stall high with empty sample register");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> s1_valid)
    else $error("accepted sample not held");

  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("qualified sample did not reach the event register");

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == teq_pkg::EV_NONE) |-> (event_x == '0 && event_y == '0))
    else $error("event of kind none carries coordinates");

endmodule
